### hdl/tws_pkg.sv
// Package for the three-wire serial master: payload structs, phase codes,
// register indexes and timing constants. No dependencies.
package tws_pkg;

    localparam int COUNT_WIDTH = 10;
    localparam int CFG_WIDTH   = 10;
    localparam int CNT_WIDTH   = 5;

    localparam logic [CNT_WIDTH-1:0] MAX_BURST = 5'd31;

    localparam logic [CFG_WIDTH-1:0] HALF_PERIOD_RESET  = 10'd50;
    localparam logic [CFG_WIDTH-1:0] ENABLE_SETUP_RESET = 10'd100;

    localparam logic [1:0] REG_HALF_PERIOD  = 2'd0;
    localparam logic [1:0] REG_ENABLE_SETUP = 2'd1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SETUP    = 3'd1,
        PH_CMD_LOW  = 3'd2,
        PH_CMD_HIGH = 3'd3,
        PH_DAT_LOW  = 3'd4,
        PH_DAT_HIGH = 3'd5,
        PH_FETCH    = 3'd6,
        PH_HOLD     = 3'd7
    } t_phase;

    typedef struct packed {
        logic       start_req;
        logic       cmd;
        logic [7:0] command_byte;
        logic [4:0] byte_count;
        logic [7:0] write_data;
        logic       io_in;
    } t_in;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_out;
        logic       io_drive;
        logic       data_request;
        logic [7:0] read_data;
        logic       read_valid;
        logic       last_byte;
        logic       busy_res;
    } t_out;

    // Per-tick events raised by the phase sequencer
    typedef struct packed {
        logic       request;
        logic       valid;
        logic       last;
        logic [7:0] rdata;
    } t_evt;

endpackage

### hdl/three_wire_serial_master_top.sv
// The result for a tick transaction is registered in the output register on acceptance.
// One tick transaction per cycle unless stalled; the phase sequencer updates once per tick.
// A full output register parts the sides: stall passes back only while it is held.
// Reset (synchronous, active low): idle phase, counters and shift data cleared,
// half_period back to 50 and enable_setup back to 100 ticks.
module three_wire_serial_master_top
    import tws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    logic [CFG_WIDTH-1:0]   r_half_period;
    logic [CFG_WIDTH-1:0]   r_enable_setup;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [2:0]             r_bit, n_bit;
    logic [7:0]             r_shift, n_shift;
    logic [CNT_WIDTH-1:0]   r_left, n_left;
    logic                   r_is_read, n_is_read;

    logic                   r_out_valid;
    t_out                   r_out, n_out;
    t_evt                   evt;

    logic                   accept;
    logic [CFG_WIDTH-1:0]   span_lim;
    logic                   span_end;
    logic [COUNT_WIDTH:0]   tick_inc;
    logic [CNT_WIDTH-1:0]   count_sat;
    logic [CNT_WIDTH-1:0]   left_dec;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period  <= HALF_PERIOD_RESET;
            r_enable_setup <= ENABLE_SETUP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HALF_PERIOD:  r_half_period  <= i_cfg_data;
                REG_ENABLE_SETUP: r_enable_setup <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Span length for the current phase; a zero register acts as one
    always_comb begin
        span_lim = (r_phase == PH_SETUP || r_phase == PH_HOLD) ? r_enable_setup
                                                               : r_half_period;
        if (span_lim == '0) begin
            span_lim = CFG_WIDTH'(1);
        end
        tick_inc = {1'b0, r_tick} + (COUNT_WIDTH+1)'(1);
        span_end = (tick_inc >= (COUNT_WIDTH+1)'(span_lim));
    end

    assign left_dec = r_left - CNT_WIDTH'(1);

    always_comb begin
        count_sat = i_data.byte_count;
        if (count_sat == '0) begin
            count_sat = CNT_WIDTH'(1);
        end
        if (count_sat > MAX_BURST) begin
            count_sat = MAX_BURST;
        end
    end

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_left    = r_left;
        n_is_read = r_is_read;
        evt       = '0;

        // Shared span counter, outside idle and fetch: restart at the end of a span, else advance
        if (r_phase != PH_IDLE && r_phase != PH_FETCH) begin
            n_tick = span_end ? '0 : tick_inc[COUNT_WIDTH-1:0];
        end

        case (r_phase)
            PH_IDLE: begin
                if (i_data.start_req) begin
                    n_is_read = i_data.cmd;
                    n_shift   = i_data.command_byte | {7'd0, i_data.cmd};
                    n_left    = count_sat;
                    n_bit     = '0;
                    n_tick    = '0;
                    n_phase   = PH_SETUP;
                end
            end
            PH_SETUP: begin
                if (span_end) n_phase = PH_CMD_LOW;
            end
            PH_CMD_LOW: begin
                if (span_end) n_phase = PH_CMD_HIGH;
            end
            PH_CMD_HIGH: begin
                if (span_end) begin
                    if (r_bit == 3'd7) begin
                        n_bit = '0;
                        if (r_is_read) begin
                            n_shift = '0;
                            n_phase = PH_DAT_LOW;
                        end else begin
                            n_phase     = PH_FETCH;
                            evt.request = 1'b1;
                            evt.last    = (r_left == CNT_WIDTH'(1));
                        end
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = PH_CMD_LOW;
                    end
                end
            end
            PH_DAT_LOW: begin
                if (span_end) begin
                    if (r_is_read) begin
                        // Sample on the last tick of the clock-low half
                        n_shift[r_bit] = r_shift[r_bit] | i_data.io_in;
                        if (r_bit == 3'd7) begin
                            evt.valid = 1'b1;
                            evt.rdata = n_shift;
                            evt.last  = (r_left == CNT_WIDTH'(1));
                        end
                    end
                    n_phase = PH_DAT_HIGH;
                end
            end
            PH_DAT_HIGH: begin
                if (span_end) begin
                    if (r_bit == 3'd7) begin
                        n_bit  = '0;
                        n_left = left_dec;
                        if (left_dec == '0) begin
                            n_phase = PH_HOLD;
                        end else if (r_is_read) begin
                            n_shift = '0;
                            n_phase = PH_DAT_LOW;
                        end else begin
                            n_phase     = PH_FETCH;
                            evt.request = 1'b1;
                            evt.last    = (left_dec == CNT_WIDTH'(1));
                        end
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = PH_DAT_LOW;
                    end
                end
            end
            PH_FETCH: begin
                n_shift = i_data.write_data;
                n_bit   = '0;
                n_tick  = '0;
                n_phase = PH_DAT_LOW;
            end
            PH_HOLD: begin
                if (span_end) n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Pin levels after this tick's update
    always_comb begin
        n_out              = '0;
        n_out.chip_enable  = (n_phase != PH_IDLE);
        n_out.busy_res     = (n_phase != PH_IDLE);
        n_out.serial_clock = (n_phase == PH_CMD_HIGH) || (n_phase == PH_DAT_HIGH);
        n_out.io_drive     = !(n_is_read && ((n_phase == PH_DAT_LOW) ||
                                              (n_phase == PH_DAT_HIGH) ||
                                              (n_phase == PH_HOLD)));
        if (n_out.io_drive && (n_phase == PH_SETUP || n_phase == PH_CMD_LOW ||
                               n_phase == PH_CMD_HIGH || n_phase == PH_DAT_LOW ||
                               n_phase == PH_DAT_HIGH)) begin
            n_out.io_out = n_shift[n_bit];
        end
        n_out.data_request = evt.request;
        n_out.read_valid   = evt.valid;
        n_out.read_data    = evt.rdata;
        n_out.last_byte    = evt.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_left      <= '0;
            r_is_read   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_left      <= n_left;
                r_is_read   <= n_is_read;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    a_busy_is_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.busy_res == r_out.chip_enable))
        else $error("busy and chip-enable disagree");

    a_read_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.read_valid) |-> !r_out.io_drive)
        else $error("read byte reported while data pin driven");

    a_no_out_undriven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.io_drive) |-> !r_out.io_out)
        else $error("data level set while pin released");

    a_last_with_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_byte) |->
            (r_out.read_valid || r_out.data_request))
        else $error("last byte flag without byte event");

    a_fetch_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(accept) && $past(evt.request)) |-> (r_phase == PH_FETCH))
        else $error("write byte request without fetch phase");

endmodule
